FILE: rtl/core/m3inv_pkg.sv
// Package for the 3x3 fixed-point matrix inverse.
// Beat structs for both channels, element width and flag types.
// No dependencies.
package m3inv_pkg;

	localparam int ELEM_W = 16;
	localparam int NUM_EL = 9;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t in_row0_col0;
		elem_t in_row0_col1;
		elem_t in_row0_col2;
		elem_t in_row1_col0;
		elem_t in_row1_col1;
		elem_t in_row1_col2;
		elem_t in_row2_col0;
		elem_t in_row2_col1;
		elem_t in_row2_col2;
	} in_beat_t;

	typedef struct packed {
		elem_t inv_row0_col0;
		elem_t inv_row0_col1;
		elem_t inv_row0_col2;
		elem_t inv_row1_col0;
		elem_t inv_row1_col1;
		elem_t inv_row1_col2;
		elem_t inv_row2_col0;
		elem_t inv_row2_col1;
		elem_t inv_row2_col2;
		logic  singular;
		logic  saturated;
	} out_beat_t;

	// Per-item flags that ride along the divider stages.
	typedef struct packed {
		logic [NUM_EL-1:0] neg;
		logic [NUM_EL-1:0] over;
		logic              sing;
	} div_flags_t;

endpackage

FILE: rtl/core/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse: adjugate over determinant.
// Uses m3inv_pkg and m3inv_div_step (one instance per lane and quotient bit).
//
//  channel | valid     | stall     | payload             | beat
//  input   | in_valid  | in_stall  | in_data  (in_beat_t)  | one matrix
//  output  | out_valid | out_stall | out_data (out_beat_t) | inverse and flags
//
// One matrix enters per cycle while in_stall is low. The pipeline has five
// product/determinant stages, one range-check stage and one divider stage per
// quotient bit in each of the nine lanes, followed by the output register.
// Reset clears only valid bits; the data registers are not reset.
// A skid register behind the output register absorbs one beat when out_stall rises;
// in_stall is that skid register's full flag, so the pipeline freezes only then.
module matrix3_inverse #(
	parameter int FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  m3inv_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output m3inv_pkg::out_beat_t out_data
);
	import m3inv_pkg::*;

	localparam int EW  = ELEM_W;
	localparam int CW  = 2 * EW + 1;
	localparam int PW  = 2 * EW;
	localparam int MW  = 2 * EW;
	localparam int TW  = EW + CW;
	localparam int DW  = 3 * EW + 3;
	localparam int DMW = DW;
	localparam int QW  = EW + 1;
	localparam int NW  = MW + 2 * FRAC_BITS;
	localparam int NHW = NW - QW;
	localparam int RW  = ((NHW > DMW) ? NHW : DMW) + 1;

	// Element pairs of the two products of each cofactor (a..i = 0..8).
	localparam int PA [0:17] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
	localparam int PB [0:17] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

	logic adv;
	logic skid_v_q;
	elem_t el [0:NUM_EL-1];

	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	assign el[0] = in_data.in_row0_col0;
	assign el[1] = in_data.in_row0_col1;
	assign el[2] = in_data.in_row0_col2;
	assign el[3] = in_data.in_row1_col0;
	assign el[4] = in_data.in_row1_col1;
	assign el[5] = in_data.in_row1_col2;
	assign el[6] = in_data.in_row2_col0;
	assign el[7] = in_data.in_row2_col1;
	assign el[8] = in_data.in_row2_col2;

	// Stage 1: the eighteen element products.
	logic                 v_s1;
	logic signed [PW-1:0] prod_s1 [0:17];
	elem_t                a_s1, d_s1, g_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 18; k++) begin
				prod_s1[k] <= PW'(el[PA[k]]) * PW'(el[PB[k]]);
			end
			a_s1 <= el[0];
			d_s1 <= el[3];
			g_s1 <= el[6];
		end
	end

	// Stage 2: cofactors.
	logic                 v_s2;
	logic signed [CW-1:0] cof_s2 [0:NUM_EL-1];
	elem_t                a_s2, d_s2, g_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_EL; k++) begin
				cof_s2[k] <= CW'(prod_s1[2*k]) - CW'(prod_s1[2*k+1]);
			end
			a_s2 <= a_s1;
			d_s2 <= d_s1;
			g_s2 <= g_s1;
		end
	end

	// Stage 3: determinant terms along column 0.
	logic                 v_s3;
	logic signed [TW-1:0] term_s3 [0:2];
	logic signed [CW-1:0] cof_s3  [0:NUM_EL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s3[0] <= TW'(a_s2) * TW'(cof_s2[0]);
			term_s3[1] <= TW'(d_s2) * TW'(cof_s2[3]);
			term_s3[2] <= TW'(g_s2) * TW'(cof_s2[6]);
			cof_s3     <= cof_s2;
		end
	end

	// Stage 4: determinant.
	logic                 v_s4;
	logic signed [DW-1:0] det_s4;
	logic signed [CW-1:0] cof_s4 [0:NUM_EL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= DW'(term_s3[0]) + DW'(term_s3[1]) + DW'(term_s3[2]);
			cof_s4 <= cof_s3;
		end
	end

	// Stage 5: magnitudes and signs. Lanes are put in output order here, so lane
	// r*3+c holds the cofactor of row c, column r (the adjugate).
	logic                    v_s5;
	logic [DMW-1:0]          dmag_s5;
	logic                    sing_s5;
	logic [NUM_EL-1:0]       neg_s5;
	logic [MW-1:0]           cmag_s5 [0:NUM_EL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s5 <= det_s4[DW-1] ? DMW'(-det_s4) : DMW'(det_s4);
			sing_s5 <= det_s4 == '0;
			for (int l = 0; l < NUM_EL; l++) begin
				neg_s5[l]  <= cof_s4[(l % 3) * 3 + l / 3][CW-1] ^ det_s4[DW-1];
				cmag_s5[l] <= cof_s4[(l % 3) * 3 + l / 3][CW-1]
					? MW'(-cof_s4[(l % 3) * 3 + l / 3])
					: MW'(cof_s4[(l % 3) * 3 + l / 3]);
			end
		end
	end

	// Divider stage 0: range check and start of the long division. A numerator
	// whose top part already reaches the divisor gives a quotient too wide to fit.
	logic       div_v     [0:QW];
	logic [DMW-1:0] div_d [0:QW];
	div_flags_t div_f     [0:QW];
	logic [RW-1:0]  div_rem [0:QW][0:NUM_EL-1];
	logic [QW-1:0]  div_low [0:QW][0:NUM_EL-1];
	logic [QW-1:0]  div_q   [0:QW][0:NUM_EL-1];

	logic [NW-1:0]  num     [0:NUM_EL-1];
	logic [RW-1:0]  num_hi  [0:NUM_EL-1];
	logic [NUM_EL-1:0] over_d;
	logic [RW-1:0]  rem0_q  [0:NUM_EL-1];
	logic [QW-1:0]  low0_q  [0:NUM_EL-1];

	always_comb begin
		for (int l = 0; l < NUM_EL; l++) begin
			num[l]    = {cmag_s5[l], {(2 * FRAC_BITS){1'b0}}};
			num_hi[l] = {{(RW-NHW){1'b0}}, num[l][NW-1:QW]};
			over_d[l] = num_hi[l] >= {{(RW-DMW){1'b0}}, dmag_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_d[0]      <= dmag_s5;
			div_f[0].neg  <= neg_s5;
			div_f[0].over <= over_d;
			div_f[0].sing <= sing_s5;
			for (int l = 0; l < NUM_EL; l++) begin
				rem0_q[l] <= over_d[l] ? '0 : num_hi[l];
				low0_q[l] <= num[l][QW-1:0];
			end
		end
	end

	for (genvar l = 0; l < NUM_EL; l++) begin : g_start
		assign div_rem[0][l] = rem0_q[l];
		assign div_low[0][l] = low0_q[l];
		assign div_q[0][l]   = '0;
	end

	// Divider stages 1..QW: one quotient bit per stage in every lane.
	for (genvar j = 0; j < QW; j++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				div_d[j+1] <= div_d[j];
				div_f[j+1] <= div_f[j];
			end
		end
		for (genvar l = 0; l < NUM_EL; l++) begin : g_lane
			m3inv_div_step #(
				.RW  (RW),
				.DMW (DMW),
				.QW  (QW)
			) u_step (
				.clk     (clk),
				.en      (adv),
				.dmag    (div_d[j]),
				.rem_in  (div_rem[j][l]),
				.low_in  (div_low[j][l]),
				.q_in    (div_q[j][l]),
				.rem_out (div_rem[j+1][l]),
				.low_out (div_low[j+1][l]),
				.q_out   (div_q[j+1][l])
			);
		end
	end

	// Valid bits for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int j = 0; j <= QW; j++) begin
				div_v[j] <= 1'b0;
			end
		end else if (adv) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			div_v[0] <= v_s5;
			for (int j = 0; j < QW; j++) begin
				div_v[j+1] <= div_v[j];
			end
		end
	end

	// Saturation, sign and the singular case.
	elem_t         res [0:NUM_EL-1];
	logic [NUM_EL-1:0] sat_l;
	logic [QW-1:0] lim;
	logic [QW-1:0] qs;
	out_beat_t     fin;

	always_comb begin
		for (int l = 0; l < NUM_EL; l++) begin
			lim = div_f[QW].neg[l] ? (QW'(1) << (EW - 1)) : (QW'(1) << (EW - 1)) - QW'(1);
			sat_l[l] = div_f[QW].over[l] || (div_q[QW][l] > lim);
			qs = sat_l[l] ? lim : div_q[QW][l];
			qs = div_f[QW].neg[l] ? -qs : qs;
			res[l] = div_f[QW].sing ? '0 : elem_t'(qs[EW-1:0]);
		end
		fin.inv_row0_col0 = res[0];
		fin.inv_row0_col1 = res[1];
		fin.inv_row0_col2 = res[2];
		fin.inv_row1_col0 = res[3];
		fin.inv_row1_col1 = res[4];
		fin.inv_row1_col2 = res[5];
		fin.inv_row2_col0 = res[6];
		fin.inv_row2_col1 = res[7];
		fin.inv_row2_col2 = res[8];
		fin.singular      = div_f[QW].sing;
		fin.saturated     = !div_f[QW].sing && (sat_l != '0);
	end

	// Output register with a one-beat skid behind it.
	logic      o_v_q;
	out_beat_t o_q, skid_q;
	logic      o_load;

	assign o_load = !o_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q    <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (o_load) begin
			o_v_q    <= skid_v_q || div_v[QW];
			skid_v_q <= 1'b0;
		end else if (div_v[QW] && adv) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_load) begin
			o_q <= skid_v_q ? skid_q : fin;
		end else if (div_v[QW] && adv) begin
			skid_q <= fin;
		end
	end

	assign out_valid = o_v_q;
	assign out_data  = o_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> o_v_q)
		else $error("skid register full while output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_stall) |=> skid_v_q)
		else $error("skid beat lost while output stalled");

	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && o_q.singular) |-> (!o_q.saturated && o_q.inv_row1_col1 == '0))
		else $error("singular result carries nonzero data or saturation");

	a_fill_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(o_v_q && out_stall && div_v[QW] && !skid_v_q) |=> skid_v_q)
		else $error("finished beat not captured in skid register");
endmodule

FILE: rtl/core/m3inv_div_step.sv
// One registered restoring-division step for one lane of the inverse.
// Produces one quotient bit per step; stands alone, no package needed.
module m3inv_div_step #(
	parameter int RW  = 52,
	parameter int DMW = 51,
	parameter int QW  = 17
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DMW-1:0] dmag,
	input  logic [RW-1:0]  rem_in,
	input  logic [QW-1:0]  low_in,
	input  logic [QW-1:0]  q_in,
	output logic [RW-1:0]  rem_out,
	output logic [QW-1:0]  low_out,
	output logic [QW-1:0]  q_out
);
	logic [RW-1:0] rem_sh;
	logic [RW-1:0] dext;
	logic          ge;
	logic [RW-1:0] rem_s1;
	logic [QW-1:0] low_s1;
	logic [QW-1:0] q_s1;

	always_comb begin
		rem_sh = {rem_in[RW-2:0], low_in[QW-1]};
		dext   = {{(RW-DMW){1'b0}}, dmag};
		ge     = rem_sh >= dext;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? rem_sh - dext : rem_sh;
			low_s1 <= {low_in[QW-2:0], 1'b0};
			q_s1   <= {q_in[QW-2:0], ge};
		end
	end

	assign rem_out = rem_s1;
	assign low_out = low_s1;
	assign q_out   = q_s1;
endmodule
